### hw/rtl/pitm_pkg.sv
// Package for the point-in-tetrahedron mesh search.
// Shared constants, request codes, the determinant unit status struct and addr_w.
// No dependencies.
package pitm_pkg;

    localparam int MAX_NODES_DEF  = 4096;
    localparam int MAX_TETS_DEF   = 4096;
    localparam int COORD_BITS_DEF = 32;

    localparam int REQ_W   = 2;
    localparam int IDX_W   = 12;
    localparam int VERT_W  = 12;
    localparam int COUNT_W = 13;
    localparam int FIELD_W = 32;
    localparam int TET_W   = 4 * VERT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_NODE  = 2'd0,
        REQ_TET   = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
    } det_stat_t;

    function automatic int addr_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

### hw/rtl/pitm_store.sv
// Node store and tetrahedron table, synchronous memories with registered read.
// Depends on pitm_pkg.
module pitm_store #(
    parameter int MAX_NODES  = pitm_pkg::MAX_NODES_DEF,
    parameter int MAX_TETS   = pitm_pkg::MAX_TETS_DEF,
    parameter int COORD_BITS = pitm_pkg::COORD_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     node_we,
    input  logic [pitm_pkg::addr_w(MAX_NODES)-1:0]   node_waddr,
    input  logic [3*COORD_BITS-1:0]                  node_wdata,
    input  logic [pitm_pkg::addr_w(MAX_NODES)-1:0]   node_raddr,
    output logic [3*COORD_BITS-1:0]                  node_rdata,
    input  logic                                     tet_we,
    input  logic [pitm_pkg::addr_w(MAX_TETS)-1:0]    tet_waddr,
    input  logic [pitm_pkg::TET_W-1:0]               tet_wdata,
    input  logic [pitm_pkg::addr_w(MAX_TETS)-1:0]    tet_raddr,
    output logic [pitm_pkg::TET_W-1:0]               tet_rdata
);
    import pitm_pkg::*;

    logic [3*COORD_BITS-1:0] node_mem [MAX_NODES];
    logic [TET_W-1:0]        tet_mem  [MAX_TETS];

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tet_we)
        begin
            tet_mem[tet_waddr] <= tet_wdata;
        end
        tet_rdata <= tet_mem[tet_raddr];
    end

endmodule

### hw/rtl/pitm_det.sv
// Sequential exact 4x4 orientation determinant, one shared multiplier.
// Depends on pitm_pkg.
module pitm_det #(
    parameter int COORD_BITS = pitm_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2:0]                   repl,
    input  logic signed [COORD_BITS-1:0] vtx [4][3],
    input  logic signed [COORD_BITS-1:0] pt [3],
    output pitm_pkg::det_stat_t          stat
);
    import pitm_pkg::*;

    localparam int DW = COORD_BITS + 1;   // coordinate difference
    localparam int OW = DW + 1;           // multiplier operand
    localparam int PW = 2 * OW;           // product
    localparam int MW = 2 * DW + 1;       // 2x2 minor
    localparam int AW = 3 * DW + 4;       // full determinant
    localparam int SW = 4;
    localparam logic [SW-1:0] OP_LAST = SW'(11);
    localparam logic [SW-1:0] ST_END  = SW'(13);

    logic signed [COORD_BITS-1:0] row [4][3];
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] w_reg [3];
    logic signed [MW-1:0] m_reg [3];
    logic signed [AW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] pe;
    logic signed [OW-1:0] ma;
    logic signed [OW-1:0] mb;
    logic signed [OW-1:0] ml [3];
    logic signed [OW-1:0] mh [3];
    logic [SW-1:0] st_reg;
    logic [SW-1:0] op_reg;
    logic          pv_reg;
    logic          busy_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                row[j][k] = (repl == 3'(j + 1)) ? pt[k] : vtx[j][k];
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            ml[k] = $signed({1'b0, m_reg[k][DW-1:0]});
            mh[k] = m_reg[k][MW-1:DW];
        end
    end

    // operand schedule: six minor products, then u times split minors
    always_comb
    begin
        case (st_reg)
            4'd0:    begin ma = OW'(v_reg[1]); mb = OW'(w_reg[2]); end
            4'd1:    begin ma = OW'(v_reg[2]); mb = OW'(w_reg[1]); end
            4'd2:    begin ma = OW'(v_reg[0]); mb = OW'(w_reg[2]); end
            4'd3:    begin ma = OW'(v_reg[2]); mb = OW'(w_reg[0]); end
            4'd4:    begin ma = OW'(v_reg[0]); mb = OW'(w_reg[1]); end
            4'd5:    begin ma = OW'(v_reg[1]); mb = OW'(w_reg[0]); end
            4'd6:    begin ma = OW'(u_reg[0]); mb = ml[0]; end
            4'd7:    begin ma = OW'(u_reg[0]); mb = mh[0]; end
            4'd8:    begin ma = OW'(u_reg[1]); mb = ml[1]; end
            4'd9:    begin ma = OW'(u_reg[1]); mb = mh[1]; end
            4'd10:   begin ma = OW'(u_reg[2]); mb = ml[2]; end
            4'd11:   begin ma = OW'(u_reg[2]); mb = mh[2]; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign pe = AW'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            st_reg   <= '0;
            pv_reg   <= 1'b0;
            op_reg   <= '0;
        end
        else
        begin
            pv_reg <= busy_reg && (st_reg <= OP_LAST);
            op_reg <= st_reg;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                st_reg   <= '0;
            end
            else if (busy_reg)
            begin
                if (st_reg == ST_END)
                begin
                    busy_reg <= 1'b0;
                end
                st_reg <= st_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                u_reg[k] <= DW'(row[0][k]) - DW'(row[3][k]);
                v_reg[k] <= DW'(row[1][k]) - DW'(row[3][k]);
                w_reg[k] <= DW'(row[2][k]) - DW'(row[3][k]);
            end
        end
        prod_reg <= ma * mb;
        if (pv_reg)
        begin
            case (op_reg)
                4'd0:    m_reg[0] <= MW'(prod_reg);
                4'd1:    m_reg[0] <= m_reg[0] - MW'(prod_reg);
                4'd2:    m_reg[1] <= MW'(prod_reg);
                4'd3:    m_reg[1] <= m_reg[1] - MW'(prod_reg);
                4'd4:    m_reg[2] <= MW'(prod_reg);
                4'd5:    m_reg[2] <= m_reg[2] - MW'(prod_reg);
                4'd6:    acc_reg  <= pe;
                4'd7:    acc_reg  <= acc_reg + (pe <<< DW);
                4'd8:    acc_reg  <= acc_reg - pe;
                4'd9:    acc_reg  <= acc_reg - (pe <<< DW);
                4'd10:   acc_reg  <= acc_reg + pe;
                4'd11:   acc_reg  <= acc_reg + (pe <<< DW);
                default: acc_reg  <= acc_reg;
            endcase
        end
    end

    assign stat.done = busy_reg && (st_reg == ST_END);
    assign stat.neg  = acc_reg[AW-1];
    assign stat.zero = (acc_reg == '0);

endmodule

### hw/rtl/point_in_tetra_mesh_search.sv
// Top level of the point-in-tetrahedron mesh search: control sequencer,
// output register. Depends on pitm_pkg, pitm_store, pitm_det.
//
//   channel | handshake               | payload
//   in      | in_valid / in_stall     | req_type entry_index coord_x/y/z vert_a..d
//   out     | out_valid / out_stall   | contained
//   cfg     | cfg_wr_en               | cfg_wr_data (tet_count)
//
// A query works through each tetrahedron in turn: the table read, the four
// vertex reads on the single node port, and the determinants on the one
// shared multiplier; it ends early on a hit. Memories are not cleared at
// reset. Input is stalled while a query runs; a waiting result does not
// stall loads.
module point_in_tetra_mesh_search #(
    parameter int MAX_NODES  = pitm_pkg::MAX_NODES_DEF,
    parameter int MAX_TETS   = pitm_pkg::MAX_TETS_DEF,
    parameter int COORD_BITS = pitm_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pitm_pkg::REQ_W-1:0]    req_type,
    input  logic [pitm_pkg::IDX_W-1:0]    entry_index,
    input  logic signed [pitm_pkg::FIELD_W-1:0] coord_x,
    input  logic signed [pitm_pkg::FIELD_W-1:0] coord_y,
    input  logic signed [pitm_pkg::FIELD_W-1:0] coord_z,
    input  logic [pitm_pkg::VERT_W-1:0]   vert_a,
    input  logic [pitm_pkg::VERT_W-1:0]   vert_b,
    input  logic [pitm_pkg::VERT_W-1:0]   vert_c,
    input  logic [pitm_pkg::VERT_W-1:0]   vert_d,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          contained,
    input  logic                          cfg_wr_en,
    input  logic [pitm_pkg::COUNT_W-1:0]  cfg_wr_data
);
    import pitm_pkg::*;

    localparam int NAW = addr_w(MAX_NODES);
    localparam int TAW = addr_w(MAX_TETS);
    localparam int CW  = $clog2(MAX_TETS + 1);
    localparam int CB  = COORD_BITS;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_TET_RD   = 8'b0000_0010,
        ST_TET_LAT  = 8'b0000_0100,
        ST_VTX_RD   = 8'b0000_1000,
        ST_VTX_WAIT = 8'b0001_0000,
        ST_DET_GO   = 8'b0010_0000,
        ST_DET_WAIT = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [COUNT_W-1:0]   tet_count_reg;
    logic [CW-1:0]        limit_reg;
    logic [CW-1:0]        tet_idx_reg;
    logic [TET_W-1:0]     tet_reg;
    logic [1:0]           vcnt_reg;
    logic                 cap_en_reg;
    logic [1:0]           cap_slot_reg;
    logic [2:0]           det_k_reg;
    logic                 s0_neg_reg;
    logic                 res_reg;
    logic                 out_valid_reg;
    logic                 contained_reg;
    logic signed [CB-1:0] vx_reg [4][3];
    logic signed [CB-1:0] pt_reg [3];

    logic                 in_xfer;
    logic                 node_we;
    logic                 tet_we;
    logic [31:0]          idx32;
    logic [31:0]          lim32;
    logic [3*CB-1:0]      node_rdata;
    logic [TET_W-1:0]     tet_rdata;
    logic [NAW-1:0]       node_raddr;
    logic [31:0]          vsel32;
    logic                 tet_bad;
    logic                 last_tet;
    logic                 det_match;
    logic                 push_out;
    det_stat_t            dstat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign idx32     = 32'(entry_index);
    assign node_we   = in_xfer && (req_type == REQ_NODE) && (idx32 < 32'(MAX_NODES));
    assign tet_we    = in_xfer && (req_type == REQ_TET) && (idx32 < 32'(MAX_TETS));
    assign lim32     = (32'(tet_count_reg) > 32'(MAX_TETS)) ? 32'(MAX_TETS)
                                                            : 32'(tet_count_reg);
    assign vsel32    = 32'(tet_reg[vcnt_reg*VERT_W +: VERT_W]);
    assign node_raddr = vsel32[NAW-1:0];
    assign last_tet  = (CW'(tet_idx_reg + 1'b1) == limit_reg);
    assign det_match = !dstat.zero && (dstat.neg == s0_neg_reg);
    assign push_out  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        tet_bad = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (32'(tet_rdata[k*VERT_W +: VERT_W]) >= 32'(MAX_NODES))
            begin
                tet_bad = 1'b1;
            end
        end
    end

    pitm_store #(
        .MAX_NODES  (MAX_NODES),
        .MAX_TETS   (MAX_TETS),
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .clk        (clk),
        .node_we    (node_we),
        .node_waddr (idx32[NAW-1:0]),
        .node_wdata ({coord_x[CB-1:0], coord_y[CB-1:0], coord_z[CB-1:0]}),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .tet_we     (tet_we),
        .tet_waddr  (idx32[TAW-1:0]),
        .tet_wdata  ({vert_d, vert_c, vert_b, vert_a}),
        .tet_raddr  (tet_idx_reg[TAW-1:0]),
        .tet_rdata  (tet_rdata)
    );

    pitm_det #(
        .COORD_BITS (COORD_BITS)
    ) u_det (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DET_GO),
        .repl  (det_k_reg),
        .vtx   (vx_reg),
        .pt    (pt_reg),
        .stat  (dstat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (req_type == REQ_QUERY))
                begin
                    state_next = (lim32 == 32'd0) ? ST_DONE : ST_TET_RD;
                end
            end
            ST_TET_RD:   state_next = ST_TET_LAT;
            ST_TET_LAT:
            begin
                if (!tet_bad)
                begin
                    state_next = ST_VTX_RD;
                end
                else
                begin
                    state_next = last_tet ? ST_DONE : ST_TET_RD;
                end
            end
            ST_VTX_RD:   state_next = (vcnt_reg == 2'd3) ? ST_VTX_WAIT : ST_VTX_RD;
            ST_VTX_WAIT: state_next = ST_DET_GO;
            ST_DET_GO:   state_next = ST_DET_WAIT;
            ST_DET_WAIT:
            begin
                if (dstat.done)
                begin
                    if ((det_k_reg == 3'd0) ? dstat.zero : !det_match)
                    begin
                        state_next = last_tet ? ST_DONE : ST_TET_RD;
                    end
                    else if (det_k_reg == 3'd4)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DET_GO;
                    end
                end
            end
            ST_DONE:     state_next = push_out ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tet_count_reg <= '0;
            out_valid_reg <= 1'b0;
            cap_en_reg    <= 1'b0;
            tet_idx_reg   <= '0;
            vcnt_reg      <= '0;
            det_k_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cap_en_reg <= (state_reg == ST_VTX_RD);
            if (cfg_wr_en)
            begin
                tet_count_reg <= cfg_wr_data;
            end
            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE)
            begin
                tet_idx_reg <= '0;
            end
            else if ((state_next == ST_TET_RD) && (state_reg != ST_TET_RD))
            begin
                tet_idx_reg <= tet_idx_reg + 1'b1;
            end
            if (state_reg == ST_VTX_RD)
            begin
                vcnt_reg <= vcnt_reg + 1'b1;
            end
            else
            begin
                vcnt_reg <= '0;
            end
            if (state_reg == ST_VTX_WAIT)
            begin
                det_k_reg <= '0;
            end
            else if ((state_reg == ST_DET_WAIT) && (state_next == ST_DET_GO))
            begin
                det_k_reg <= det_k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cap_slot_reg <= vcnt_reg;
        if (in_xfer && (req_type == REQ_QUERY))
        begin
            pt_reg[0] <= coord_x[CB-1:0];
            pt_reg[1] <= coord_y[CB-1:0];
            pt_reg[2] <= coord_z[CB-1:0];
            limit_reg <= CW'(lim32);
            res_reg   <= 1'b0;
        end
        if (state_reg == ST_TET_LAT)
        begin
            tet_reg <= tet_rdata;
        end
        if (cap_en_reg)
        begin
            vx_reg[cap_slot_reg][0] <= node_rdata[3*CB-1:2*CB];
            vx_reg[cap_slot_reg][1] <= node_rdata[2*CB-1:CB];
            vx_reg[cap_slot_reg][2] <= node_rdata[CB-1:0];
        end
        if ((state_reg == ST_DET_WAIT) && dstat.done)
        begin
            if (det_k_reg == 3'd0)
            begin
                s0_neg_reg <= dstat.neg;
            end
            else if ((det_k_reg == 3'd4) && det_match)
            begin
                res_reg <= 1'b1;
            end
        end
        if (push_out)
        begin
            contained_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign contained = contained_reg;

endmodule

### hw/rtl/pitm_chk.sv
// Port-level checker for point_in_tetra_mesh_search, attached by bind.
// Depends on pitm_pkg.
module pitm_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [pitm_pkg::REQ_W-1:0]  req_type,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        contained
);
    import pitm_pkg::*;

    // a held result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(contained))
        else $error("result changed while stalled");

    // the search occupies the block right after a query transfer
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_QUERY) |=> in_stall)
        else $error("query transfer did not start a search");

    // a fresh result appears only as a search ends
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $fell(in_stall))
        else $error("result without a finished search");

endmodule

bind point_in_tetra_mesh_search pitm_chk u_pitm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .contained (contained)
);

### test/tb_point_in_tetra_mesh_search.sv
// Testbench for point_in_tetra_mesh_search: directed and random loads/queries,
// checked against an exact signed-determinant containment predictor.
// Depends on pitm_pkg and the point_in_tetra_mesh_search RTL.
`timescale 1ns / 100ps

import pitm_pkg::*;

typedef longint vec3_t[3];

typedef struct {
    logic [REQ_W-1:0]          kind;
    logic [IDX_W-1:0]          slot;
    logic signed [FIELD_W-1:0] x, y, z;
    logic [VERT_W-1:0]         va, vb, vc, vd;
} mesh_req_t;

class containment_board;
    longint            nx[MAX_NODES_DEF], ny[MAX_NODES_DEF], nz[MAX_NODES_DEF];
    logic [VERT_W-1:0] tv[MAX_TETS_DEF][4];
    int unsigned       tet_count;
    bit                hit_q[$];
    int                errors;

    function int orient(vec3_t p, vec3_t q, vec3_t r, vec3_t s);
        logic signed [127:0] u[3], v[3], w[3];
        logic signed [127:0] m0, m1, m2, acc;
        for (int k = 0; k < 3; k++)
        begin
            u[k] = 128'(p[k] - s[k]);
            v[k] = 128'(q[k] - s[k]);
            w[k] = 128'(r[k] - s[k]);
        end
        m0  = v[1] * w[2] - v[2] * w[1];
        m1  = v[0] * w[2] - v[2] * w[0];
        m2  = v[0] * w[1] - v[1] * w[0];
        acc = u[0] * m0 - u[1] * m1 + u[2] * m2;
        if (acc < 0)
            return -1;
        return (acc != 0) ? 1 : 0;
    endfunction

    function bit point_inside(vec3_t pt);
        int unsigned n;
        vec3_t       c[4];
        int          s0;
        n = (tet_count > MAX_TETS_DEF) ? MAX_TETS_DEF : tet_count;
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                c[k][0] = nx[tv[i][k]];
                c[k][1] = ny[tv[i][k]];
                c[k][2] = nz[tv[i][k]];
            end
            s0 = orient(c[0], c[1], c[2], c[3]);
            if (s0 == 0)
                continue;
            if (orient(pt, c[1], c[2], c[3]) == s0 && orient(c[0], pt, c[2], c[3]) == s0 &&
                orient(c[0], c[1], pt, c[3]) == s0 && orient(c[0], c[1], c[2], pt) == s0)
                return 1;
        end
        return 0;
    endfunction

    function void note_request(mesh_req_t it);
        vec3_t pt;
        pt[0] = longint'(it.x);
        pt[1] = longint'(it.y);
        pt[2] = longint'(it.z);
        if (it.kind == REQ_NODE)
        begin
            nx[it.slot] = pt[0];
            ny[it.slot] = pt[1];
            nz[it.slot] = pt[2];
        end
        else if (it.kind == REQ_TET)
        begin
            tv[it.slot][0] = it.va;
            tv[it.slot][1] = it.vb;
            tv[it.slot][2] = it.vc;
            tv[it.slot][3] = it.vd;
        end
        else if (it.kind == REQ_QUERY)
            hit_q.push_back(point_inside(pt));
    endfunction

    function void check_result(logic got);
        bit want;
        if (hit_q.size() == 0)
        begin
            $error("unexpected result: contained=%0d", got);
            errors++;
            return;
        end
        want = hit_q.pop_front();
        if (got !== want)
        begin
            $error("contained: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module tb_point_in_tetra_mesh_search;

    localparam logic [REQ_W-1:0] REQ_BOGUS = 2'd3;
    localparam int IDLE_LIMIT = 30000;
    localparam int ONE = 1 << 16;

    logic                      clk = 0;
    logic                      rst_n = 0;
    logic                      in_valid = 0;
    logic                      in_stall;
    logic [REQ_W-1:0]          req_type = '0;
    logic [IDX_W-1:0]          entry_index = '0;
    logic signed [FIELD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic [VERT_W-1:0]         vert_a = '0, vert_b = '0, vert_c = '0, vert_d = '0;
    logic                      out_valid;
    logic                      out_stall = 0;
    logic                      contained;
    logic                      cfg_wr_en = 0;
    logic [COUNT_W-1:0]        cfg_wr_data = '0;

    containment_board board = new();
    bit       quiet;
    int       hold_cycles;
    int       idle_cycles;
    bit       node_seen[MAX_NODES_DEF];
    int       seen_list[$];

    point_in_tetra_mesh_search DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .entry_index(entry_index),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .vert_a(vert_a), .vert_b(vert_b), .vert_c(vert_c), .vert_d(vert_d),
        .out_valid(out_valid), .out_stall(out_stall), .contained(contained),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // receiver: long hold-off when asked, no stall when quiet, else random stall bursts
    always @(negedge clk)
    begin
        int burst;
        if (hold_cycles > 0)
        begin
            out_stall = 1;
            hold_cycles--;
        end
        else if (quiet)
            out_stall = 0;
        else if (burst > 0)
            burst--;
        else if ($urandom_range(0, 5) == 0)
        begin
            burst     = $urandom_range(1, 11);
            out_stall = ~out_stall;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_result(contained);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_req(input mesh_req_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_type    = it.kind;
        entry_index = it.slot;
        coord_x     = it.x;
        coord_y     = it.y;
        coord_z     = it.z;
        vert_a      = it.va;
        vert_b      = it.vb;
        vert_c      = it.vc;
        vert_d      = it.vd;
        in_valid    = 1;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(it);
        if (it.kind == REQ_NODE && !node_seen[it.slot])
        begin
            node_seen[it.slot] = 1;
            seen_list.push_back(int'(it.slot));
        end
        @(negedge clk);
    endtask

    task automatic load_node(input int slot, input int x, input int y, input int z);
        mesh_req_t it;
        it = '{REQ_NODE, IDX_W'(slot), x, y, z, VERT_W'($urandom), VERT_W'($urandom),
               VERT_W'($urandom), VERT_W'($urandom)};
        send_req(it);
    endtask

    task automatic load_tet(input int slot, input int a, input int b, input int c,
                            input int d);
        mesh_req_t it;
        it = '{REQ_TET, IDX_W'(slot), $urandom, $urandom, $urandom,
               VERT_W'(a), VERT_W'(b), VERT_W'(c), VERT_W'(d)};
        send_req(it);
    endtask

    task automatic ask(input int x, input int y, input int z);
        mesh_req_t it;
        it = '{REQ_QUERY, IDX_W'($urandom), x, y, z, VERT_W'($urandom), VERT_W'($urandom),
               VERT_W'($urandom), VERT_W'($urandom)};
        send_req(it);
    endtask

    // idle point: every result back, then a margin for trailing loads
    task automatic drain();
        in_valid = 0;
        while (board.hit_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(negedge clk);
    endtask

    task automatic set_count(input int v);
        cfg_wr_data = COUNT_W'(v);
        cfg_wr_en   = 1;
        @(negedge clk);
        cfg_wr_en   = 0;
        board.tet_count = v;
    endtask

    function automatic int small_coord();
        return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    endfunction

    task automatic ask_centroid(input int t, input int jitter);
        longint sx, sy, sz;
        sx = 0;
        sy = 0;
        sz = 0;
        for (int k = 0; k < 4; k++)
        begin
            sx += board.nx[board.tv[t][k]];
            sy += board.ny[board.tv[t][k]];
            sz += board.nz[board.tv[t][k]];
        end
        ask(int'(sx / 4) + jitter, int'(sy / 4) - jitter, int'(sz / 4) + jitter);
    endtask

    task automatic random_item(input int span);
        int r;
        mesh_req_t it;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            if ($urandom_range(0, 1))
                load_node($urandom_range(0, 4095), small_coord(), small_coord(),
                          small_coord());
            else
                load_node($urandom_range(0, 4095), $urandom, $urandom, $urandom);
        end
        else if (r < 45)
            load_tet(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, span + 2),
                     seen_list[$urandom_range(0, seen_list.size() - 1)],
                     seen_list[$urandom_range(0, seen_list.size() - 1)],
                     seen_list[$urandom_range(0, seen_list.size() - 1)],
                     seen_list[$urandom_range(0, seen_list.size() - 1)]);
        else if (r < 50)
        begin
            it = '{REQ_BOGUS, IDX_W'($urandom), $urandom, $urandom, $urandom,
                   VERT_W'($urandom), VERT_W'($urandom), VERT_W'($urandom),
                   VERT_W'($urandom)};
            send_req(it);
        end
        else if (r < 80 && span > 0)
            ask_centroid($urandom_range(0, span - 1), $urandom_range(0, 3) - 1);
        else if (r < 90)
            ask(small_coord(), small_coord(), small_coord());
        else
            ask($urandom, $urandom, $urandom);
    endtask

    initial
    begin
        int span;
        quiet       = 0;
        hold_cycles = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // unit tetrahedron at nodes 0..3, in every table slot a query searches
        quiet = 1;
        set_count(0);
        load_node(0, 0, 0, 0);
        load_node(1, ONE, 0, 0);
        load_node(2, 0, ONE, 0);
        load_node(3, 0, 0, ONE);
        for (int t = 0; t < 16; t++)
            load_tet(t, 0, 1, 2, 3);
        quiet = 0;

        // no tetrahedra searched
        ask(ONE / 4, ONE / 4, ONE / 4);
        load_node(4095, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        load_node(4094, 32'h80000000, 32'h80000000, 32'h80000000);
        load_node(5, ONE, ONE, 0);
        load_tet(1, 4095, 4094, 1, 2);
        load_tet(2, 0, 1, 2, 5);       // flat: all four in z = 0
        load_tet(4095, 4095, 1, 2, 3);
        send_req('{REQ_BOGUS, 12'hfff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                   12'hfff, 12'hfff, 12'hfff, 12'hfff});
        drain();

        set_count(3);
        ask(ONE / 4, ONE / 4, ONE / 4);        // interior
        ask(0, 0, 0);                          // on a vertex
        ask(ONE / 4, ONE / 4, 0);              // on a face
        ask(-1, -1, -1);                       // just outside
        ask(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        ask(32'h80000000, 32'h80000000, 32'h80000000);
        ask(0, 0, 1);
        drain();

        // counts at and above the table size; first tetrahedron hits
        set_count(13'h1fff);
        ask(ONE / 4, ONE / 4, ONE / 4);
        drain();
        set_count(4096);
        ask(ONE / 5, ONE / 5, ONE / 5);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            span = (ph == 0) ? 1 : $urandom_range(2, 12);
            set_count(span);
            quiet = (ph == 5);
            for (int i = 0; i < 17; i++)
            begin
                if (ph == 2 && i == 4)
                    hold_cycles = 3000;
                random_item(span);
            end
            drain();
        end

        if (board.errors == 0 && board.hit_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### point_in_tetra_mesh_search.f
hw/rtl/pitm_pkg.sv
hw/rtl/pitm_store.sv
hw/rtl/pitm_det.sv
hw/rtl/point_in_tetra_mesh_search.sv
hw/rtl/pitm_chk.sv
test/tb_point_in_tetra_mesh_search.sv
